FILE: hw/rtl/hle_pkg.sv
// Shared types, constants and defaults for the hue LED PWM encoder.
package hle_pkg;

  localparam int MAX_LEDS_DEF    = 1024;
  localparam int LUX_MAX_DEF     = 8;
  localparam int SCALE_MUL_DEF   = 17;
  localparam int SCALE_SHIFT_DEF = 2;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int IDX_W   = 10;
  localparam int HUE_W   = 16;
  localparam int QUOT_W  = 9;
  localparam int NLED_W  = 11;
  localparam int COLOR_W = 24;

  localparam logic [7:0] UNSET = 8'hFF;

  localparam logic [2:0] REG_LUX      = 3'd0;
  localparam logic [2:0] REG_MODE     = 3'd1;
  localparam logic [2:0] REG_SHIFT    = 3'd2;
  localparam logic [2:0] REG_NUM_LEDS = 3'd3;
  localparam logic [2:0] REG_LOW_DUTY = 3'd4;

  localparam logic [7:0] MODE_RAINBOW = 8'd0;
  localparam logic [7:0] MODE_RED     = 8'd1;
  localparam logic [7:0] MODE_GREEN   = 8'd2;
  localparam logic [7:0] MODE_BLUE    = 8'd3;
  localparam logic [7:0] MODE_NEON    = 8'd4;

  localparam logic [QUOT_W-1:0] HUE_FULL_Q = 9'd360;

  typedef struct packed {
    logic [7:0]        lux;
    logic [7:0]        color_mode;
    logic [7:0]        hue_shift;
    logic [6:0]        low_duty;
    logic [HUE_W-1:0]  step;
    logic              busy;
  } hle_cfg_t;

  typedef struct packed {
    logic               err;
    logic [COLOR_W-1:0] color;
  } hle_item_t;

endpackage

FILE: hw/rtl/hle_cfg_regs.sv
// Configuration registers, hue step divider and step product.
module hle_cfg_regs import hle_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEF,
  parameter int LUX_MAX  = LUX_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output hle_cfg_t    cfg
);

  localparam logic [7:0]  LUX_MAX_B = 8'(LUX_MAX);
  localparam logic [16:0] MAX_L     = 17'(MAX_LEDS);

  logic [7:0]        lux_r, mode_r, shift_r;
  logic [NLED_W-1:0] num_leds_r;
  logic [6:0]        low_duty_r;
  logic [QUOT_W-1:0] quot_r;
  logic [NLED_W-1:0] rem_r;
  logic [3:0]        div_cnt_r;
  logic              settle_r;
  logic [HUE_W-1:0]  step_r;

  logic              wr;
  logic [2:0]        idx;
  logic [NLED_W-1:0] n_in, n_sat;
  logic [NLED_W:0]   trial;
  logic [16:0]       step_prod;

  assign wr    = psel & penable & pwrite;
  assign idx   = paddr[4:2];
  assign n_in  = pwdata[NLED_W-1:0];
  assign n_sat = ({6'd0, n_in} > MAX_L) ? MAX_L[NLED_W-1:0] : n_in;
  assign trial = {rem_r, HUE_FULL_Q[div_cnt_r - 4'd1]};
  assign step_prod = quot_r * shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lux_r      <= UNSET;
      mode_r     <= UNSET;
      shift_r    <= UNSET;
      num_leds_r <= NLED_W'(1);
      low_duty_r <= 7'd30;
      quot_r     <= HUE_FULL_Q;
      rem_r      <= '0;
      div_cnt_r  <= '0;
      settle_r   <= 1'b1;
    end else begin
      settle_r <= wr | (div_cnt_r == 4'd1);
      if (div_cnt_r != 4'd0) begin
        div_cnt_r <= div_cnt_r - 4'd1;
        if (trial >= {1'b0, num_leds_r}) begin
          rem_r  <= NLED_W'(trial - {1'b0, num_leds_r});
          quot_r <= {quot_r[QUOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= trial[NLED_W-1:0];
          quot_r <= {quot_r[QUOT_W-2:0], 1'b0};
        end
      end
      if (wr) begin
        unique case (idx)
          REG_LUX: begin
            if (pwdata[7:0] <= LUX_MAX_B) lux_r <= pwdata[7:0];
          end
          REG_MODE:  mode_r  <= {5'd0, pwdata[2:0]};
          REG_SHIFT: shift_r <= pwdata[7:0];
          REG_NUM_LEDS: begin
            num_leds_r <= n_sat;
            div_cnt_r  <= 4'(QUOT_W);
            rem_r      <= '0;
            quot_r     <= '0;
          end
          REG_LOW_DUTY: low_duty_r <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= (num_leds_r == '0) ? '0 : step_prod[HUE_W-1:0];
  end

  always_comb begin
    unique case (idx)
      REG_LUX:      prdata = {24'd0, lux_r};
      REG_MODE:     prdata = {24'd0, mode_r};
      REG_SHIFT:    prdata = {24'd0, shift_r};
      REG_NUM_LEDS: prdata = {21'd0, num_leds_r};
      REG_LOW_DUTY: prdata = {25'd0, low_duty_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.lux        = lux_r;
  assign cfg.color_mode = mode_r;
  assign cfg.hue_shift  = shift_r;
  assign cfg.low_duty   = low_duty_r;
  assign cfg.step       = step_r;
  assign cfg.busy       = settle_r | (div_cnt_r != 4'd0);

endmodule

FILE: hw/rtl/hle_front.sv
// Front pipeline: hue product, hue shaping and hue-to-GRB conversion.
module hle_front import hle_pkg::*; #(
  parameter int LUX_MAX     = LUX_MAX_DEF,
  parameter int SCALE_MUL   = SCALE_MUL_DEF,
  parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             kind,
  input  logic [IDX_W-1:0] led_index,
  input  hle_cfg_t         cfg,
  output logic             push,
  output hle_item_t        item
);

  localparam logic [7:0]  LUX_MAX_B = 8'(LUX_MAX);
  localparam logic [15:0] M360      = 16'd46604;
  localparam logic [16:0] M63       = 17'd66577;

  function automatic logic [7:0] ramp(input logic [5:0] h);
    logic [13:0] p;
    p = 14'(h * SCALE_MUL);
    return 8'(p >> SCALE_SHIFT);
  endfunction

  function automatic logic [HUE_W-1:0] neon_hue(input logic [3:0] sel);
    logic [HUE_W-1:0] h;
    unique case (sel)
      4'd1, 4'd3: h = 16'd330;
      4'd2, 4'd5: h = 16'd0;
      4'd4, 4'd6: h = 16'd60;
      default:    h = 16'd240;
    endcase
    return h;
  endfunction

  logic             v1_r, v2_r, v3_r, v4_r;
  logic             kind1_r, kind2_r, kind3_r;
  logic             err1_r, err2_r, err3_r, err4_r;
  logic [IDX_W-1:0] idx1_r;
  logic [3:0]       idx2_r;
  logic [HUE_W-1:0] hue1_r, hue2_r, hue3_r;
  logic [7:0]       q360_r;
  logic [10:0]      q63_r;
  logic [COLOR_W-1:0] color4_r;

  logic [25:0]      p1;
  logic [31:0]      p360;
  logic [32:0]      p63;
  logic [HUE_W-1:0] m360, m63, r360, r63, shaped;
  logic [7:0]       r, g, b, sh;
  logic             unset;

  assign p1    = led_index * cfg.step;
  assign unset = (cfg.lux == UNSET) | (cfg.color_mode == UNSET) | (cfg.hue_shift == UNSET);
  assign p360  = hue1_r * M360;
  assign p63   = hue1_r * M63;

  always_comb begin
    m360 = 16'({8'd0, q360_r} * 16'd360);
    m63  = 16'({5'd0, q63_r} * 16'd63);
    r360 = hue2_r - m360;
    r63  = hue2_r - m63;
    if (r360 >= 16'd360) r360 = r360 - 16'd360;
    if (r63 >= 16'd63)   r63  = r63 - 16'd63;
    unique case (cfg.color_mode)
      MODE_RAINBOW: shaped = r360;
      MODE_RED:     shaped = r63;
      MODE_GREEN:   shaped = {10'd0, hue2_r[5:0]} + 16'd90;
      MODE_BLUE:    shaped = {10'd0, hue2_r[5:0]} + 16'd180;
      MODE_NEON:    shaped = neon_hue(idx2_r);
      default:      shaped = hue2_r;
    endcase
  end

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    priority if (hue3_r <= 16'd60) begin
      r = 8'hFF;
      g = ramp(6'(hue3_r));
    end else if (hue3_r <= 16'd120) begin
      r = ramp(6'(16'd120 - hue3_r));
      g = 8'hFF;
    end else if (hue3_r <= 16'd180) begin
      g = 8'hFF;
      b = ramp(6'(hue3_r - 16'd120));
    end else if (hue3_r <= 16'd240) begin
      g = ramp(6'(16'd240 - hue3_r));
      b = 8'hFF;
    end else if (hue3_r <= 16'd300) begin
      r = ramp(6'(hue3_r - 16'd240));
      b = 8'hFF;
    end else if (hue3_r <= 16'd360) begin
      r = 8'hFF;
      b = ramp(6'(16'd360 - hue3_r));
    end
    sh = LUX_MAX_B - cfg.lux;
    if (sh > 8'd8) sh = 8'd8;
    r = r >> sh;
    g = g >> sh;
    b = b >> sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    kind1_r  <= kind;
    err1_r   <= ~kind & unset;
    idx1_r   <= led_index;
    hue1_r   <= p1[HUE_W-1:0];
    kind2_r  <= kind1_r;
    err2_r   <= err1_r;
    idx2_r   <= idx1_r[3:0];
    hue2_r   <= hue1_r;
    q360_r   <= p360[31:24];
    q63_r    <= p63[32:22];
    kind3_r  <= kind2_r;
    err3_r   <= err2_r;
    hue3_r   <= shaped;
    err4_r   <= err3_r;
    color4_r <= kind3_r ? '0 : {g, r, b};
  end

  assign push       = v4_r;
  assign item.err   = err4_r;
  assign item.color = color4_r;

endmodule

FILE: hw/rtl/hle_fifo.sv
// Small queue between the front pipeline and the bit serializer.
module hle_fifo import hle_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);

endmodule

FILE: hw/rtl/hle_back.sv
// Bit serializer: 24 duty bytes per LED, MSB first, or one error transaction.
module hle_back import hle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hle_item_t  q_item,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic [6:0] low_duty,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  logic               active_r, err_r;
  logic [COLOR_W-1:0] color_r;
  logic [4:0]         cnt_r;
  logic               valid_r, last_r, status_r;
  logic [7:0]         duty_r;
  logic               advance, emit, done;

  assign advance = ~valid_r | out_tready;
  assign emit    = advance & active_r;
  assign done    = emit & (err_r | (cnt_r == 5'(COLOR_W - 1)));
  assign q_pop   = (~active_r | done) & ~q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (advance) valid_r <= active_r;
      if (q_pop)     active_r <= 1'b1;
      else if (done) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (err_r) begin
        duty_r   <= '0;
        last_r   <= 1'b1;
        status_r <= 1'b1;
      end else begin
        duty_r   <= color_r[COLOR_W-1] ? {low_duty, 1'b0} : {1'b0, low_duty};
        last_r   <= (cnt_r == 5'(COLOR_W - 1));
        status_r <= 1'b0;
      end
      color_r <= {color_r[COLOR_W-2:0], 1'b0};
      cnt_r   <= cnt_r + 5'd1;
    end
    if (q_pop) begin
      err_r   <= q_item.err;
      color_r <= q_item.color;
      cnt_r   <= '0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = duty_r;
  assign out_tlast  = last_r;
  assign out_tuser  = status_r;

endmodule

FILE: hw/rtl/hue_led_pwm_encoder_core.sv
// Top level of the hue LED PWM encoder: channels, credit count and checks.
//
// Input stream (in_*): one transaction per LED. in_tuser is the kind (0 render,
// 1 blank), in_tdata[9:0] is the LED index. Output stream (out_*): one
// transaction per duty byte in out_tdata, MSB first in G,R,B order; out_tlast
// marks the 24th byte of an LED; out_tuser is status (1 = lux, color mode or
// hue shift still unset, single transaction with duty 0).
// Throughput: the serializer emits one byte per cycle while out_tready is
// high; the front pipeline takes one LED per cycle while in_tready is high
// and up to QUEUE_DEPTH LEDs may be in flight. A stall on out_tready freezes
// the output register; the front keeps filling the queue until its credits
// run out. Register writes over the APB port (cfg_*) are taken every cycle;
// a num_leds write runs the hue step divider and holds in_tready low until
// the step is recomputed, other writes until the step register reloads.
// Reset (rst_n low, synchronous) restores register defaults and empties
// the queue; in_tready rises the cycle after release.
module hue_led_pwm_encoder_core import hle_pkg::*; #(
  parameter int MAX_LEDS    = MAX_LEDS_DEF,
  parameter int LUX_MAX     = LUX_MAX_DEF,
  parameter int SCALE_MUL   = SCALE_MUL_DEF,
  parameter int SCALE_SHIFT = SCALE_SHIFT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [9:0] led_index, [15:10] zero
  input  logic        in_tuser,     // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] duty
  output logic        out_tlast,
  output logic        out_tuser,    // [0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

  hle_cfg_t          cfg;
  hle_item_t         f_item, q_item;
  logic              f_push, q_pop, q_empty, in_acc;
  logic [CRED_W-1:0] credits_r;

  assign cfg_pready = 1'b1;
  assign in_acc     = in_tvalid & in_tready;
  assign in_tready  = ~cfg.busy & (credits_r < CRED_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credits_r <= '0;
    end else if (in_acc && !q_pop) begin
      credits_r <= credits_r + 1'b1;
    end else if (q_pop && !in_acc) begin
      credits_r <= credits_r - 1'b1;
    end
  end

  hle_cfg_regs #(
    .MAX_LEDS (MAX_LEDS),
    .LUX_MAX  (LUX_MAX)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  hle_front #(
    .LUX_MAX     (LUX_MAX),
    .SCALE_MUL   (SCALE_MUL),
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .kind      (in_tuser),
    .led_index (in_tdata[IDX_W-1:0]),
    .cfg       (cfg),
    .push      (f_push),
    .item      (f_item)
  );

  hle_fifo #(
    .WIDTH ($bits(hle_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  hle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .low_duty   (cfg.low_duty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credits_r <= CRED_W'(QUEUE_DEPTH))
    else $error("credit count above queue depth");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.busy |-> !in_tready)
    else $error("input ready while step is being recomputed");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata == 8'd0))
    else $error("error transaction without last or with nonzero duty");

  a_pop_needs_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (credits_r != '0))
    else $error("queue pop without an outstanding transaction");
`endif

endmodule

FILE: test/hue_led_pwm_encoder_core_tb.sv
// Testbench for hue_led_pwm_encoder_core: stream stimulus, APB setup and a duty-byte scoreboard.
`timescale 1ns / 100ps

import hle_pkg::*;

localparam logic KIND_RENDER = 1'b0;
localparam logic KIND_BLANK  = 1'b1;

typedef struct packed {
  logic [7:0] duty;
  logic       last;
  logic       status;
} duty_beat_t;

class duty_scoreboard;
  logic [7:0]  lux_reg;
  logic [7:0]  mode_reg;
  logic [7:0]  shift_reg;
  logic [10:0] nleds_reg;
  logic [6:0]  low_duty_reg;
  duty_beat_t  pending_beats[$];
  int          errors;

  function new();
    errors = 0;
    reset_regs();
  endfunction

  function void reset_regs();
    lux_reg      = UNSET;
    mode_reg     = UNSET;
    shift_reg    = UNSET;
    nleds_reg    = 11'd1;
    low_duty_reg = 7'd30;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_LUX:      if (v[7:0] <= LUX_MAX_DEF) lux_reg = v[7:0];
      REG_MODE:     mode_reg = {5'd0, v[2:0]};
      REG_SHIFT:    shift_reg = v[7:0];
      REG_NUM_LEDS: nleds_reg = (v[10:0] > MAX_LEDS_DEF) ? 11'(MAX_LEDS_DEF) : v[10:0];
      REG_LOW_DUTY: low_duty_reg = v[6:0];
      default: ;
    endcase
  endfunction

  function int unsigned ramp(int unsigned h);
    return ((h * SCALE_MUL_DEF) >> SCALE_SHIFT_DEF) & 32'hFF;
  endfunction

  function int unsigned shaped_hue(int unsigned hue, logic [9:0] idx);
    case (mode_reg)
      MODE_RAINBOW: return hue % 360;
      MODE_RED:     return hue % 63;
      MODE_GREEN:   return (hue & 32'h3F) + 90;
      MODE_BLUE:    return (hue & 32'h3F) + 180;
      MODE_NEON: begin
        case (idx[3:0])
          4'd1, 4'd3: return 330;
          4'd2, 4'd5: return 0;
          4'd4, 4'd6: return 60;
          default:    return 240;
        endcase
      end
      default: return hue;
    endcase
  endfunction

  function logic [23:0] pixel_grb(logic [9:0] idx);
    int unsigned step, hue, h, r, g, b, sh;
    step = (nleds_reg == 0) ? 0 : 360 / nleds_reg;
    step = (step * shift_reg) & 32'hFFFF;
    hue  = (idx * step) & 32'hFFFF;
    h    = shaped_hue(hue, idx);
    r = 0;
    g = 0;
    b = 0;
    if (h <= 60) begin
      r = 255; g = ramp(h);
    end else if (h <= 120) begin
      r = ramp(120 - h); g = 255;
    end else if (h <= 180) begin
      g = 255; b = ramp(h - 120);
    end else if (h <= 240) begin
      g = ramp(240 - h); b = 255;
    end else if (h <= 300) begin
      r = ramp(h - 240); b = 255;
    end else if (h <= 360) begin
      r = 255; b = ramp(360 - h);
    end
    sh = (lux_reg > LUX_MAX_DEF) ? 8 : LUX_MAX_DEF - lux_reg;
    r = r >> sh;
    g = g >> sh;
    b = b >> sh;
    return {g[7:0], r[7:0], b[7:0]};
  endfunction

  function void note_input(logic kind, logic [9:0] idx);
    logic [23:0] grb;
    duty_beat_t  beat;
    if (kind == KIND_RENDER && (lux_reg == UNSET || mode_reg == UNSET || shift_reg == UNSET))
    begin
      beat.duty   = 8'd0;
      beat.last   = 1'b1;
      beat.status = 1'b1;
      pending_beats.push_back(beat);
      return;
    end
    grb = (kind == KIND_RENDER) ? pixel_grb(idx) : 24'd0;
    for (int k = 23; k >= 0; k--) begin
      beat.duty   = grb[k] ? {low_duty_reg, 1'b0} : {1'b0, low_duty_reg};
      beat.last   = (k == 0);
      beat.status = 1'b0;
      pending_beats.push_back(beat);
    end
  endfunction

  task report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  task check_result(logic [7:0] duty, logic last, logic status);
    duty_beat_t want;
    if (pending_beats.size() == 0) begin
      report_mismatch("unexpected transaction duty", int'(duty), -1);
      return;
    end
    want = pending_beats.pop_front();
    if (duty !== want.duty) report_mismatch("duty", int'(duty), int'(want.duty));
    if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
    if (status !== want.status) report_mismatch("status", int'(status), int'(want.status));
  endtask

  function int pending();
    return pending_beats.size();
  endfunction
endclass

module hue_led_pwm_encoder_core_tb;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [9:0] led_index, [15:10] zero
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] duty
  logic        out_tlast;
  logic        out_tuser;  // [0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  duty_scoreboard sb;
  int             hold_cycles;
  int             sink_gap;
  bit             no_idle;

  hue_led_pwm_encoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // receiver: an optional long hold-off first, then random stall bursts unless no_idle is set
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else if (sink_gap > 0) begin
      out_tready = 1'b0;
      sink_gap--;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_tready = 1'b0;
      sink_gap = $urandom_range(1, 10) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata[9:0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  task send_item(logic kind, logic [9:0] idx);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {6'd0, idx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task drain();
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task cfg_write(logic [2:0] idx, logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task set_config(logic [7:0] lux, logic [7:0] mode, logic [7:0] shift, logic [10:0] nleds,
                  logic [7:0] duty);
    cfg_write(REG_LUX, {24'd0, lux});
    cfg_write(REG_MODE, {24'd0, mode});
    cfg_write(REG_SHIFT, {24'd0, shift});
    cfg_write(REG_NUM_LEDS, {21'd0, nleds});
    cfg_write(REG_LOW_DUTY, {24'd0, duty});
  endtask

  task random_phase(int n_items, bit pressure, bit mid_drain);
    logic [7:0]  lux_v, mode_v, shift_v, duty_v;
    logic [10:0] nleds_v;
    int          d;
    logic        kind;
    logic [9:0]  idx;
    lux_v   = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, LUX_MAX_DEF))
                                         : 8'($urandom_range(0, 255));
    mode_v  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 4));
    shift_v = ($urandom_range(0, 15) == 0) ? UNSET : 8'($urandom_range(0, 254));
    if ($urandom_range(0, 9) < 7) begin
      do d = $urandom_range(1, 360); while (360 % d != 0);
      nleds_v = 11'(d);
    end else begin
      nleds_v = 11'($urandom_range(0, 2047));
    end
    duty_v = 8'($urandom_range(0, 255));
    set_config(lux_v, mode_v, shift_v, nleds_v, duty_v);
    if (pressure) hold_cycles = 300;
    for (int i = 0; i < n_items; i++) begin
      kind = ($urandom_range(0, 4) == 0) ? KIND_BLANK : KIND_RENDER;
      idx  = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 15))
                                         : 10'($urandom_range(0, 1023));
      send_item(kind, idx);
      if (mid_drain && i == n_items / 2) drain();
    end
    drain();
  endtask

  initial begin
    #5_000_000;
    $display("FAIL hue_led_pwm_encoder_core");
    $finish;
  end

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_cycles = 0;
    sink_gap    = 0;
    no_idle     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // settings unset after reset; blank ignores them
    send_item(KIND_RENDER, 10'd0);
    send_item(KIND_BLANK, 10'd1023);
    drain();
    cfg_write(REG_LUX, 32'd9);          // out of range, dropped
    send_item(KIND_RENDER, 10'd5);
    drain();
    cfg_write(REG_LUX, 32'd8);
    send_item(KIND_RENDER, 10'd7);
    drain();
    cfg_write(REG_MODE, {24'd0, MODE_RAINBOW});
    send_item(KIND_RENDER, 10'd9);
    drain();
    cfg_write(REG_SHIFT, 32'd1);
    send_item(KIND_RENDER, 10'd1);
    drain();

    set_config(8'd8, MODE_RAINBOW, 8'd1, 11'd6, 8'd30);
    send_item(KIND_RENDER, 10'd0);
    send_item(KIND_RENDER, 10'd1);
    send_item(KIND_RENDER, 10'd1023);
    send_item(KIND_RENDER, 10'd512);
    send_item(KIND_BLANK, 10'd0);
    drain();

    // unassigned mode, hue at and past 360
    set_config(8'd8, 8'd5, 8'd1, 11'd1, 8'd127);
    send_item(KIND_RENDER, 10'd1);
    send_item(KIND_RENDER, 10'd2);
    send_item(KIND_RENDER, 10'd0);
    drain();

    set_config(8'd4, MODE_NEON, 8'd3, 11'd12, 8'd0);
    for (int i = 0; i <= 6; i++) send_item(KIND_RENDER, 10'(i));
    send_item(KIND_RENDER, 10'd15);
    drain();

    // zero LED count
    set_config(8'd0, MODE_RED, 8'd200, 11'd0, 8'd64);
    send_item(KIND_RENDER, 10'd100);
    drain();

    // masked mode, saturated LED count
    set_config(8'd8, 8'hFA, 8'd7, 11'd2047, 8'd99);
    send_item(KIND_RENDER, 10'd1023);
    drain();

    // hue shift back to unset
    set_config(8'd6, MODE_BLUE, UNSET, 11'd10, 8'd45);
    send_item(KIND_RENDER, 10'd3);
    send_item(KIND_BLANK, 10'd3);
    drain();

    set_config(8'd5, MODE_GREEN, 8'd9, 11'd360, 8'd17);
    send_item(KIND_RENDER, 10'd700);
    drain();

    for (int p = 0; p < 10; p++) begin
      no_idle = (p >= 8);
      random_phase(26, p == 2, p == 5);
    end

    if (sb.errors == 0) begin
      $display("PASS hue_led_pwm_encoder_core");
    end else begin
      $display("FAIL hue_led_pwm_encoder_core");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/hle_pkg.sv
hw/rtl/hle_cfg_regs.sv
hw/rtl/hle_front.sv
hw/rtl/hle_fifo.sv
hw/rtl/hle_back.sv
hw/rtl/hue_led_pwm_encoder_core.sv
test/hue_led_pwm_encoder_core_tb.sv
